// ===== rtl/core/thick_line_round_cap_tessellator_macros.svh =====
// Assertion helpers used by the tessellator emitter.
`ifndef THICK_LINE_ROUND_CAP_TESSELLATOR_MACROS_SVH
`define THICK_LINE_ROUND_CAP_TESSELLATOR_MACROS_SVH

// Same-cycle implication under active-low reset.
`define TLRC_IMPLY(name, ck, rn, pre, post) \
	name: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
		else $error("tessellator check failed");

// Next-cycle implication under active-low reset.
`define TLRC_NEXT(name, ck, rn, pre, post) \
	name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
		else $error("tessellator check failed");

`endif

// ===== rtl/core/tlrc_pkg.sv =====
package tlrc_pkg;

	localparam logic [15:0] W_MIN = 16'd256;
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic signed [23:0] start_x;
		logic signed [23:0] start_y;
		logic signed [23:0] end_x;
		logic signed [23:0] end_y;
		logic [15:0]        pen_width;
		logic [31:0]        pen_color;
		logic               start_cap;
		logic               batch_last;
	} seg_in_t;

	typedef struct packed {
		logic signed [23:0] ax;
		logic signed [23:0] ay;
		logic signed [23:0] bx;
		logic signed [23:0] by;
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic [31:0]        tri_color;
		logic               segment_done;
		logic               batch_done;
	} tri_out_t;

	typedef struct packed {
		logic signed [23:0] sx;
		logic signed [23:0] sy;
		logic signed [23:0] ex;
		logic signed [23:0] ey;
		logic [15:0]        w;
		logic [31:0]        color;
		logic               cap;
		logic               last;
		logic               zero;
	} seg_t;

	typedef struct packed {
		seg_t        s;
		logic [40:0] mx;
		logic [40:0] my;
		logic        neg_x;
		logic        neg_y;
	} frt_t;

	typedef struct packed {
		seg_t        s;
		logic [17:0] qx;
		logic [17:0] qy;
		logic        neg_x;
		logic        neg_y;
	} geo_t;

	typedef struct packed {
		logic signed [17:0] c;
		logic signed [17:0] s;
	} trig_t;

	function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
		if (v > 25'sd8388607) return 24'sh7FFFFF;
		else if (v < -25'sd8388608) return 24'sh800000;
		else return v[23:0];
	endfunction

	// cos/sin in Q16 for a phase in 1/65536 turn; elaboration only
	function automatic trig_t trig_q16(input int unsigned p);
		int unsigned quad;
		longint unsigned f;
		longint x, x2, t, sv, cv;
		trig_t r;
		quad = (p >> 14) & 3;
		f = longint'(p & 16383);
		x = longint'((f * HALF_PI_Q30) >> 14);
		x2 = longint'((longint'(unsigned'(x)) * longint'(unsigned'(x))) >>> 30);
		t = Q30_ONE - x2 / 110;
		t = Q30_ONE - (x2 * t / Q30_ONE) / 72;
		t = Q30_ONE - (x2 * t / Q30_ONE) / 42;
		t = Q30_ONE - (x2 * t / Q30_ONE) / 20;
		t = Q30_ONE - (x2 * t / Q30_ONE) / 6;
		sv = x * t / Q30_ONE;
		t = Q30_ONE - x2 / 132;
		t = Q30_ONE - (x2 * t / Q30_ONE) / 90;
		t = Q30_ONE - (x2 * t / Q30_ONE) / 56;
		t = Q30_ONE - (x2 * t / Q30_ONE) / 30;
		t = Q30_ONE - (x2 * t / Q30_ONE) / 12;
		cv = Q30_ONE - (x2 * t / Q30_ONE) / 2;
		if (cv < 0) cv = 0;
		if (sv < 0) sv = 0;
		sv = (sv + 8192) / 16384;
		cv = (cv + 8192) / 16384;
		case (quad)
			0: begin r.c = 18'(cv); r.s = 18'(sv); end
			1: begin r.c = 18'(-sv); r.s = 18'(cv); end
			2: begin r.c = 18'(-cv); r.s = 18'(-sv); end
			default: begin r.c = 18'(sv); r.s = 18'(-cv); end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/tlrc_sqrt.sv =====
module tlrc_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  tlrc_pkg::frt_t    in_frt,
	input  logic [61:0]       rad,
	output logic              out_v,
	output tlrc_pkg::frt_t    out_frt,
	output logic [30:0]       root
);
	localparam int NST = 16;
	localparam int RW = 63;

	logic           v_s   [NST];
	tlrc_pkg::frt_t f_s   [NST];
	logic [RW-1:0]  rem_s [NST];
	logic [RW-1:0]  res_s [NST];

	for (genvar j = 0; j < NST; j++) begin : g_st
		logic           val_i;
		tlrc_pkg::frt_t f_i;
		logic [RW-1:0]  rem_i, res_i, rem_o, res_o;

		if (j == 0) begin : g_first
			assign val_i = in_v;
			assign f_i = in_frt;
			assign rem_i = {1'b0, rad};
			assign res_i = '0;
		end else begin : g_next
			assign val_i = v_s[j-1];
			assign f_i = f_s[j-1];
			assign rem_i = rem_s[j-1];
			assign res_i = res_s[j-1];
		end

		// two root bits per stage
		always_comb begin
			logic [RW-1:0] b;
			rem_o = rem_i;
			res_o = res_i;
			for (int i = 0; i < 2; i++) begin
				b = RW'(1) << (62 - 2 * (2 * j + i));
				if (rem_o >= res_o + b) begin
					rem_o = rem_o - (res_o + b);
					res_o = (res_o >> 1) + b;
				end else begin
					res_o = res_o >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= val_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[j] <= f_i;
				rem_s[j] <= rem_o;
				res_s[j] <= res_o;
			end
		end
	end

	assign out_v = v_s[NST-1];
	assign out_frt = f_s[NST-1];
	assign root = res_s[NST-1][30:0];

endmodule

// ===== rtl/core/tlrc_div.sv =====
module tlrc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  tlrc_pkg::frt_t    in_frt,
	input  logic [30:0]       root,
	output logic              out_v,
	output tlrc_pkg::geo_t    out_geo
);
	localparam int NST = 6;
	localparam int BPS = 3;
	localparam int QW = NST * BPS;

	// stage 0 forms the rounded dividend; stages 1..NST are quotient steps
	logic            v_s    [NST+1];
	tlrc_pkg::seg_t  seg_s  [NST+1];
	logic [1:0]      neg_s  [NST+1];
	logic [31:0]     den_s  [NST+1];
	logic [31:0]     rem_s  [NST+1][2];
	logic [QW-1:0]   low_s  [NST+1][2];
	logic [QW-1:0]   quo_s  [NST+1][2];

	logic [46:0] num0 [2];
	assign num0[0] = {in_frt.mx, 6'b0} + 47'(root);
	assign num0[1] = {in_frt.my, 6'b0} + 47'(root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s[0] <= in_frt.s;
			neg_s[0] <= {in_frt.neg_y, in_frt.neg_x};
			den_s[0] <= {root, 1'b0};
			for (int l = 0; l < 2; l++) begin
				rem_s[0][l] <= {3'b0, num0[l][46:QW]};
				low_s[0][l] <= num0[l][QW-1:0];
				quo_s[0][l] <= '0;
			end
		end
	end

	for (genvar j = 1; j <= NST; j++) begin : g_st
		logic [31:0]   rem_o [2];
		logic [QW-1:0] quo_o [2];

		always_comb begin
			logic [32:0] t;
			for (int l = 0; l < 2; l++) begin
				rem_o[l] = rem_s[j-1][l];
				quo_o[l] = quo_s[j-1][l];
				for (int i = 0; i < BPS; i++) begin
					t = {rem_o[l], low_s[j-1][l][QW-1-BPS*(j-1)-i]};
					if (t >= {1'b0, den_s[j-1]}) begin
						rem_o[l] = 32'(t - {1'b0, den_s[j-1]});
						quo_o[l][QW-1-BPS*(j-1)-i] = 1'b1;
					end else begin
						rem_o[l] = t[31:0];
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				seg_s[j] <= seg_s[j-1];
				neg_s[j] <= neg_s[j-1];
				den_s[j] <= den_s[j-1];
				for (int l = 0; l < 2; l++) begin
					rem_s[j][l] <= rem_o[l];
					low_s[j][l] <= low_s[j-1][l];
					quo_s[j][l] <= quo_o[l];
				end
			end
		end
	end

	assign out_v = v_s[NST];
	assign out_geo.s = seg_s[NST];
	assign out_geo.qx = quo_s[NST][0];
	assign out_geo.qy = quo_s[NST][1];
	assign out_geo.neg_x = neg_s[NST][0];
	assign out_geo.neg_y = neg_s[NST][1];

endmodule

// ===== rtl/core/tlrc_emit.sv =====
`include "thick_line_round_cap_tessellator_macros.svh"

module tlrc_emit #(
	parameter int CAP_STEPS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               geo_valid,
	input  tlrc_pkg::geo_t     geo,
	output logic               take,
	output logic               tri_valid,
	input  logic               tri_stall,
	output tlrc_pkg::tri_out_t tri_data
);
	localparam int KW = $clog2(CAP_STEPS);
	localparam logic [1:0] K_QUAD = 2'd0;
	localparam logic [1:0] K_DSTART = 2'd1;
	localparam logic [1:0] K_DEND = 2'd2;

	logic signed [17:0] cos_tab [CAP_STEPS];
	logic signed [17:0] sin_tab [CAP_STEPS];

	for (genvar k = 0; k < CAP_STEPS; k++) begin : g_tab
		localparam int PH = (k * 65536 + CAP_STEPS / 2) / CAP_STEPS;
		localparam tlrc_pkg::trig_t TV = tlrc_pkg::trig_q16(PH);
		assign cos_tab[k] = TV.c;
		assign sin_tab[k] = TV.s;
	end

	typedef struct packed {
		logic [1:0]         kind;
		logic               qsel;
		logic signed [17:0] c0, s0, c1, s1;
		logic signed [23:0] ox, oy;
		tlrc_pkg::geo_t     g;
		logic               sdone, bdone;
	} e1_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               qsel;
		logic signed [34:0] p0x, p0y, p1x, p1y;
		logic signed [23:0] ox, oy;
		logic signed [23:0] qax, qay, qbx, qby, qcx, qcy, qdx, qdy;
		logic [31:0]        color;
		logic               sdone, bdone;
	} e2_t;

	logic           en, is_last, busy_q;
	logic [1:0]     kind_q;
	logic [KW-1:0]  k_q, k_n;
	tlrc_pkg::geo_t seg_q;
	logic           e1_v_s1, e2_v_s2;
	e1_t            e1_s1;
	e2_t            e2_s2;

	assign en = !tri_valid || !tri_stall;
	assign is_last = (kind_q == K_DEND || (kind_q == K_DSTART && seg_q.s.zero))
		&& k_q == KW'(CAP_STEPS - 1);
	assign take = geo_valid && en && (!busy_q || is_last);
	assign k_n = (k_q == KW'(CAP_STEPS - 1)) ? '0 : k_q + KW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= K_QUAD;
			k_q <= '0;
		end else if (en) begin
			if (take) begin
				busy_q <= 1'b1;
				kind_q <= geo.s.zero ? K_DSTART : K_QUAD;
				k_q <= '0;
			end else if (busy_q) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end else begin
					case (kind_q)
						K_QUAD: begin
							if (k_q[0]) begin
								kind_q <= seg_q.s.cap ? K_DSTART : K_DEND;
								k_q <= '0;
							end else begin
								k_q <= k_n;
							end
						end
						K_DSTART: begin
							if (k_q == KW'(CAP_STEPS - 1)) begin
								kind_q <= K_DEND;
								k_q <= '0;
							end else begin
								k_q <= k_n;
							end
						end
						default: k_q <= k_n;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && take) seg_q <= geo;
	end

	// stage 1: triangle command and table lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) e1_v_s1 <= 1'b0;
		else if (en) e1_v_s1 <= busy_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1.kind <= kind_q;
			e1_s1.qsel <= k_q[0];
			e1_s1.c0 <= cos_tab[k_q];
			e1_s1.s0 <= sin_tab[k_q];
			e1_s1.c1 <= cos_tab[k_n];
			e1_s1.s1 <= sin_tab[k_n];
			e1_s1.ox <= (kind_q == K_DEND) ? seg_q.s.ex : seg_q.s.sx;
			e1_s1.oy <= (kind_q == K_DEND) ? seg_q.s.ey : seg_q.s.sy;
			e1_s1.g <= seg_q;
			e1_s1.sdone <= is_last;
			e1_s1.bdone <= is_last && seg_q.s.last;
		end
	end

	// stage 2: disc offsets products, quad corners
	logic signed [16:0] wsig;
	logic signed [18:0] nx, ny;
	assign wsig = $signed({1'b0, e1_s1.g.s.w});
	assign nx = e1_s1.g.neg_x ? -$signed({1'b0, e1_s1.g.qx}) : $signed({1'b0, e1_s1.g.qx});
	assign ny = e1_s1.g.neg_y ? -$signed({1'b0, e1_s1.g.qy}) : $signed({1'b0, e1_s1.g.qy});

	function automatic logic signed [23:0] addsat(input logic signed [23:0] a,
		input logic signed [18:0] b);
		return tlrc_pkg::sat24($signed({a[23], a}) + $signed({{6{b[18]}}, b}));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) e2_v_s2 <= 1'b0;
		else if (en) e2_v_s2 <= e1_v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e2_s2.kind <= e1_s1.kind;
			e2_s2.qsel <= e1_s1.qsel;
			e2_s2.p0x <= e1_s1.c0 * wsig;
			e2_s2.p0y <= e1_s1.s0 * wsig;
			e2_s2.p1x <= e1_s1.c1 * wsig;
			e2_s2.p1y <= e1_s1.s1 * wsig;
			e2_s2.ox <= e1_s1.ox;
			e2_s2.oy <= e1_s1.oy;
			e2_s2.qax <= addsat(e1_s1.g.s.sx, nx);
			e2_s2.qay <= addsat(e1_s1.g.s.sy, ny);
			e2_s2.qbx <= addsat(e1_s1.g.s.sx, -nx);
			e2_s2.qby <= addsat(e1_s1.g.s.sy, -ny);
			e2_s2.qcx <= addsat(e1_s1.g.s.ex, nx);
			e2_s2.qcy <= addsat(e1_s1.g.s.ey, ny);
			e2_s2.qdx <= addsat(e1_s1.g.s.ex, -nx);
			e2_s2.qdy <= addsat(e1_s1.g.s.ey, -ny);
			e2_s2.color <= e1_s1.g.s.color;
			e2_s2.sdone <= e1_s1.sdone;
			e2_s2.bdone <= e1_s1.bdone;
		end
	end

	// round to nearest, ties away from zero, over 2^17
	function automatic logic signed [18:0] rnd17(input logic signed [34:0] p);
		logic [34:0] mag;
		logic [17:0] q;
		mag = p[34] ? 35'(-p) : 35'(p);
		q = 18'((mag + 35'd65536) >> 17);
		return p[34] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	// stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tri_valid <= 1'b0;
		else if (en) tri_valid <= e2_v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (e2_s2.kind)
				K_QUAD: begin
					tri_data.ax <= e2_s2.qsel ? e2_s2.qcx : e2_s2.qax;
					tri_data.ay <= e2_s2.qsel ? e2_s2.qcy : e2_s2.qay;
					tri_data.bx <= e2_s2.qbx;
					tri_data.by <= e2_s2.qby;
					tri_data.cx <= e2_s2.qsel ? e2_s2.qdx : e2_s2.qcx;
					tri_data.cy <= e2_s2.qsel ? e2_s2.qdy : e2_s2.qcy;
				end
				default: begin
					tri_data.ax <= e2_s2.ox;
					tri_data.ay <= e2_s2.oy;
					tri_data.bx <= addsat(e2_s2.ox, rnd17(e2_s2.p0x));
					tri_data.by <= addsat(e2_s2.oy, rnd17(e2_s2.p0y));
					tri_data.cx <= addsat(e2_s2.ox, rnd17(e2_s2.p1x));
					tri_data.cy <= addsat(e2_s2.oy, rnd17(e2_s2.p1y));
				end
			endcase
			tri_data.tri_color <= e2_s2.color;
			tri_data.segment_done <= e2_s2.sdone;
			tri_data.batch_done <= e2_s2.bdone;
		end
	end

	`TLRC_IMPLY(a_quad_nonzero, clk, arst_n, busy_q && kind_q == K_QUAD, !seg_q.s.zero && k_q <= KW'(1))
	`TLRC_NEXT(a_last_frees, clk, arst_n, en && busy_q && is_last && !take, !busy_q)
	`TLRC_IMPLY(a_batch_done, clk, arst_n, tri_valid && tri_data.batch_done, tri_data.segment_done)

endmodule

// ===== rtl/core/thick_line_round_cap_tessellator.sv =====
// Thick line tessellator with round caps.
// Input channel seg_valid/seg_stall/seg_data carries one pen segment per request;
// output channel tri_valid/tri_stall/tri_data carries one triangle per request.
// A request moves on a rising edge with valid high and stall low.
// A zero-length segment yields CAP_STEPS disc triangles, any other segment
// 2 quad triangles, an optional start disc and an end disc (2 + 2*CAP_STEPS max).
// segment_done marks a segment's last triangle, batch_done that and batch_last.
// A request passes 3 front stages, a 16-stage square root at two root bits per
// stage, a 7-stage divider (dividend setup then six stages of three quotient
// bits), then 4 emitter stages: segment register, lookup, products, output.
// Throughput: one triangle per cycle while tri_stall is low, set by the single
// triangle output port; a segment yields 12, 14 or 26 triangles at CAP_STEPS of
// 12, and the next one is taken in the cycle the emitter issues the current
// one's last triangle.
// Reset clears every valid bit and the emitter's control state; no memories need clearing.
// When tri_valid and tri_stall are both high the emitter holds; the front stages
// keep moving until a segment waits at the divider output; seg_stall is high while one waits.
module thick_line_round_cap_tessellator #(
	parameter int CAP_STEPS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_stall,
	input  tlrc_pkg::seg_in_t  seg_data,
	output logic               tri_valid,
	input  logic               tri_stall,
	output tlrc_pkg::tri_out_t tri_data
);
	logic en, take, div_v, sq_v;
	tlrc_pkg::geo_t div_geo;
	tlrc_pkg::frt_t sq_frt;
	logic [30:0] root;

	assign en = !div_v || take;
	assign seg_stall = !en;

	// stage 1: differences, width clamp
	logic v_s1, v_s2, v_s3;
	tlrc_pkg::seg_t seg_s1, seg_s2;
	logic signed [24:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1.sx <= seg_data.start_x;
			seg_s1.sy <= seg_data.start_y;
			seg_s1.ex <= seg_data.end_x;
			seg_s1.ey <= seg_data.end_y;
			seg_s1.w <= (seg_data.pen_width < tlrc_pkg::W_MIN) ? tlrc_pkg::W_MIN
				: seg_data.pen_width;
			seg_s1.color <= seg_data.pen_color;
			seg_s1.cap <= seg_data.start_cap;
			seg_s1.last <= seg_data.batch_last;
			seg_s1.zero <= seg_data.start_x == seg_data.end_x
				&& seg_data.start_y == seg_data.end_y;
			dx_s1 <= $signed({seg_data.end_x[23], seg_data.end_x})
				- $signed({seg_data.start_x[23], seg_data.start_x});
			dy_s1 <= $signed({seg_data.end_y[23], seg_data.end_y})
				- $signed({seg_data.start_y[23], seg_data.start_y});
		end
	end

	// stage 2: squares and normal numerators
	logic [24:0] adx, ady;
	logic [40:0] mx_s2, my_s2;
	logic [49:0] sqx_s2, sqy_s2;
	logic        negx_s2, negy_s2;
	assign adx = dx_s1[24] ? 25'(-dx_s1) : 25'(dx_s1);
	assign ady = dy_s1[24] ? 25'(-dy_s1) : 25'(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s2 <= seg_s1;
			mx_s2 <= 41'(ady) * 41'(seg_s1.w);
			my_s2 <= 41'(adx) * 41'(seg_s1.w);
			sqx_s2 <= 50'(adx) * 50'(adx);
			sqy_s2 <= 50'(ady) * 50'(ady);
			negx_s2 <= !dy_s1[24] && dy_s1 != 25'sd0;
			negy_s2 <= dx_s1[24];
		end
	end

	// stage 3: radicand
	tlrc_pkg::frt_t frt_s3;
	logic [61:0]    rad_s3;
	logic [50:0]    sq_sum;
	assign sq_sum = 51'(sqx_s2) + 51'(sqy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			frt_s3.s <= seg_s2;
			frt_s3.mx <= mx_s2;
			frt_s3.my <= my_s2;
			frt_s3.neg_x <= negx_s2;
			frt_s3.neg_y <= negy_s2;
			rad_s3 <= {sq_sum[49:0], 12'b0};
		end
	end

	tlrc_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s3),
		.in_frt  (frt_s3),
		.rad     (rad_s3),
		.out_v   (sq_v),
		.out_frt (sq_frt),
		.root    (root)
	);

	tlrc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (sq_v),
		.in_frt  (sq_frt),
		.root    (root),
		.out_v   (div_v),
		.out_geo (div_geo)
	);

	tlrc_emit #(
		.CAP_STEPS (CAP_STEPS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.geo_valid (div_v),
		.geo       (div_geo),
		.take      (take),
		.tri_valid (tri_valid),
		.tri_stall (tri_stall),
		.tri_data  (tri_data)
	);

endmodule

// ===== tb/sv/thick_line_round_cap_tessellator_tb.sv =====
module thick_line_round_cap_tessellator_tb;

	localparam int DISC_STEPS = 12;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam longint CYCLE_LIMIT = 400000;

	logic                clk;
	logic                arst_n;
	logic                seg_valid;
	logic                seg_stall;
	tlrc_pkg::seg_in_t   seg_data;
	logic                tri_valid;
	logic                tri_stall;
	tlrc_pkg::tri_out_t  tri_data;

	tlrc_pkg::tri_out_t expected_tris[$];
	int       fail_count;
	longint   cycle_count;
	bit       hold_off_req;
	bit       hold_off_active;

	thick_line_round_cap_tessellator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg_data(seg_data),
		.tri_valid(tri_valid),
		.tri_stall(tri_stall),
		.tri_data(tri_data)
	);

	always #6 clk = ~clk;

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint clamp_coord(input longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic longint round_div(input longint num, input longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = num < 0 ? longint'(-num) : num;
		q = (2 * mag + den) / (2 * den);
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void cos_sin(input int unsigned p, output longint c, output longint s);
		int unsigned quad;
		longint unsigned f;
		longint unsigned ux;
		longint x, x2, t, sv, cv;
		quad = (p >> 14) & 3;
		f = p & 16383;
		x = longint'((f * QUARTER_TURN_Q30) >> 14);
		ux = x;
		x2 = longint'((ux * ux) >> 30);
		t = ONE_Q30 - x2 / 110;
		t = ONE_Q30 - (x2 * t / ONE_Q30) / 72;
		t = ONE_Q30 - (x2 * t / ONE_Q30) / 42;
		t = ONE_Q30 - (x2 * t / ONE_Q30) / 20;
		t = ONE_Q30 - (x2 * t / ONE_Q30) / 6;
		sv = x * t / ONE_Q30;
		t = ONE_Q30 - x2 / 132;
		t = ONE_Q30 - (x2 * t / ONE_Q30) / 90;
		t = ONE_Q30 - (x2 * t / ONE_Q30) / 56;
		t = ONE_Q30 - (x2 * t / ONE_Q30) / 30;
		t = ONE_Q30 - (x2 * t / ONE_Q30) / 12;
		cv = ONE_Q30 - (x2 * t / ONE_Q30) / 2;
		if (cv < 0) cv = 0;
		if (sv < 0) sv = 0;
		sv = (sv + 8192) / 16384;
		cv = (cv + 8192) / 16384;
		case (quad)
			0: begin c = cv; s = sv; end
			1: begin c = -sv; s = cv; end
			2: begin c = -cv; s = -sv; end
			default: begin c = sv; s = -cv; end
		endcase
	endfunction

	function automatic tlrc_pkg::tri_out_t make_tri(input longint v[6],
			input logic [31:0] color);
		tlrc_pkg::tri_out_t t;
		t.ax = 24'(clamp_coord(v[0]));
		t.ay = 24'(clamp_coord(v[1]));
		t.bx = 24'(clamp_coord(v[2]));
		t.by = 24'(clamp_coord(v[3]));
		t.cx = 24'(clamp_coord(v[4]));
		t.cy = 24'(clamp_coord(v[5]));
		t.tri_color = color;
		t.segment_done = 1'b0;
		t.batch_done = 1'b0;
		return t;
	endfunction

	task automatic add_expected(input tlrc_pkg::tri_out_t t);
		expected_tris = {expected_tris, t};
	endtask

	task automatic queue_disc(input longint cx, input longint cy, input longint w,
			input logic [31:0] color);
		longint px[DISC_STEPS];
		longint py[DISC_STEPS];
		longint v[6];
		longint c, s;
		int unsigned p;
		for (int i = 0; i < DISC_STEPS; i++) begin
			p = (i * 65536 + DISC_STEPS / 2) / DISC_STEPS;
			cos_sin(p, c, s);
			px[i] = clamp_coord(cx + round_div(c * w, 131072));
			py[i] = clamp_coord(cy + round_div(s * w, 131072));
		end
		for (int i = 0; i < DISC_STEPS; i++) begin
			v[0] = cx; v[1] = cy;
			v[2] = px[i]; v[3] = py[i];
			v[4] = px[(i + 1) % DISC_STEPS]; v[5] = py[(i + 1) % DISC_STEPS];
			add_expected(make_tri(v, color));
		end
	endtask

	task automatic predict_triangles(input tlrc_pkg::seg_in_t seg);
		longint sx, sy, ex, ey, w, dx, dy, nx, ny;
		longint unsigned sq, len;
		longint v[6];
		tlrc_pkg::tri_out_t t;
		sx = seg.start_x; sy = seg.start_y;
		ex = seg.end_x; ey = seg.end_y;
		w = seg.pen_width < tlrc_pkg::W_MIN ? 256 : seg.pen_width;
		if (sx == ex && sy == ey) begin
			queue_disc(sx, sy, w, seg.pen_color);
		end else begin
			dx = ex - sx;
			dy = ey - sy;
			sq = dx * dx + dy * dy;
			len = int_sqrt(sq << 12);
			nx = round_div(-dy * w * 32, len);
			ny = round_div(dx * w * 32, len);
			v[0] = sx + nx; v[1] = sy + ny;
			v[2] = sx - nx; v[3] = sy - ny;
			v[4] = ex + nx; v[5] = ey + ny;
			add_expected(make_tri(v, seg.pen_color));
			v[0] = ex + nx; v[1] = ey + ny;
			v[2] = sx - nx; v[3] = sy - ny;
			v[4] = ex - nx; v[5] = ey - ny;
			add_expected(make_tri(v, seg.pen_color));
			if (seg.start_cap) queue_disc(sx, sy, w, seg.pen_color);
			queue_disc(ex, ey, w, seg.pen_color);
		end
		t = expected_tris.pop_back();
		t.segment_done = 1'b1;
		t.batch_done = seg.batch_last;
		add_expected(t);
	endtask

	task automatic send_segment(input tlrc_pkg::seg_in_t seg);
		int g;
		g = gap_cycles();
		@(negedge clk);
		if (g > 0) begin
			seg_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		seg_data <= seg;
		seg_valid <= 1'b1;
		do @(posedge clk); while (seg_stall);
		predict_triangles(seg);
	endtask

	task automatic idle_input();
		@(negedge clk);
		seg_valid <= 1'b0;
	endtask

	function automatic logic signed [23:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 24'($signed($urandom_range(0, 8191)) - 4096);
		if (r < 8) return 24'($urandom);
		return r == 8 ? 24'sh7FFFFF : 24'sh800000;
	endfunction

	function automatic tlrc_pkg::seg_in_t rand_segment();
		tlrc_pkg::seg_in_t s;
		s.start_x = rand_coord();
		s.start_y = rand_coord();
		if ($urandom_range(0, 9) == 0) begin
			s.end_x = s.start_x;
			s.end_y = s.start_y;
		end else begin
			s.end_x = rand_coord();
			s.end_y = rand_coord();
		end
		s.pen_width = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4096));
		s.pen_color = $urandom;
		s.start_cap = 1'($urandom_range(0, 1));
		s.batch_last = 1'($urandom_range(0, 1));
		return s;
	endfunction

	function automatic tlrc_pkg::seg_in_t mk(input int sx, input int sy, input int ex,
			input int ey, input int w, input logic [31:0] col, input bit cap, input bit last);
		tlrc_pkg::seg_in_t s;
		s.start_x = 24'(sx); s.start_y = 24'(sy);
		s.end_x = 24'(ex); s.end_y = 24'(ey);
		s.pen_width = 16'(w); s.pen_color = col;
		s.start_cap = cap; s.batch_last = last;
		return s;
	endfunction

	task automatic test_directed();
		send_segment(mk(0, 0, 0, 0, 0, 32'h00000000, 1, 0));
		send_segment(mk(100, -200, 100, -200, 512, 32'hFFFFFFFF, 0, 1));
		send_segment(mk(0, 0, 2560, 0, 255, 32'h12345678, 0, 0));
		send_segment(mk(0, 0, 0, 2560, 256, 32'h87654321, 1, 1));
		send_segment(mk(-1000, 500, 3000, -700, 65535, 32'hA5A5A5A5, 1, 0));
		send_segment(mk(0, 0, 1, 0, 1024, 32'h5A5A5A5A, 0, 1));
		send_segment(mk(-8388608, -8388608, 8388607, 8388607, 65535, 32'hDEADBEEF, 1, 1));
		send_segment(mk(8388607, 0, 8388607, 0, 65535, 32'h0F0F0F0F, 0, 0));
		send_segment(mk(-8388608, 8388607, -8388608, -8388608, 4096, 32'hF0F0F0F0, 1, 0));
		send_segment(mk(8388607, 8388607, -8388608, -8388608, 1, 32'h01020304, 0, 1));
		send_segment(mk(-8388608, 0, -8388608, 0, 32768, 32'h80000001, 1, 1));
		send_segment(mk(300, 300, 299, 301, 700, 32'h7FFFFFFE, 1, 0));
		idle_input();
	endtask

	task automatic test_random();
		for (int i = 0; i < 160; i++) send_segment(rand_segment());
		idle_input();
	endtask

	task automatic test_backpressure();
		hold_off_req = 1'b1;
		for (int i = 0; i < 30; i++) send_segment(rand_segment());
		idle_input();
		wait (!hold_off_active);
	endtask

	always @(posedge clk) begin
		tlrc_pkg::tri_out_t e;
		cycle_count <= cycle_count + 1;
		if (arst_n && tri_valid && !tri_stall) begin
			if (expected_tris.size() == 0) begin
				$error("triangle with none expected: %p", tri_data);
				fail_count++;
			end else begin
				e = expected_tris.pop_front();
				if (tri_data.ax !== e.ax) begin
					$error("ax exp %0d got %0d", e.ax, tri_data.ax); fail_count++;
				end
				if (tri_data.ay !== e.ay) begin
					$error("ay exp %0d got %0d", e.ay, tri_data.ay); fail_count++;
				end
				if (tri_data.bx !== e.bx) begin
					$error("bx exp %0d got %0d", e.bx, tri_data.bx); fail_count++;
				end
				if (tri_data.by !== e.by) begin
					$error("by exp %0d got %0d", e.by, tri_data.by); fail_count++;
				end
				if (tri_data.cx !== e.cx) begin
					$error("cx exp %0d got %0d", e.cx, tri_data.cx); fail_count++;
				end
				if (tri_data.cy !== e.cy) begin
					$error("cy exp %0d got %0d", e.cy, tri_data.cy); fail_count++;
				end
				if (tri_data.tri_color !== e.tri_color) begin
					$error("tri_color exp %h got %h", e.tri_color, tri_data.tri_color);
					fail_count++;
				end
				if (tri_data.segment_done !== e.segment_done) begin
					$error("segment_done exp %b got %b", e.segment_done, tri_data.segment_done);
					fail_count++;
				end
				if (tri_data.batch_done !== e.batch_done) begin
					$error("batch_done exp %b got %b", e.batch_done, tri_data.batch_done);
					fail_count++;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int n;
		tri_stall = 1'b0;
		hold_off_active = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_off_active = 1'b1;
				tri_stall <= 1'b1;
				repeat (400) @(negedge clk);
				tri_stall <= 1'b0;
				hold_off_active = 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				n = gap_cycles();
				if (n > 0) begin
					tri_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
				tri_stall <= 1'b0;
			end else if ($urandom_range(0, 1) == 0) begin
				repeat (30) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("thick_line_round_cap_tessellator_tb: FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		seg_valid = 1'b0;
		seg_data = '0;
		fail_count = 0;
		cycle_count = 0;
		hold_off_req = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random();
		wait (expected_tris.size() == 0);
		repeat (60) @(negedge clk);
		if (fail_count == 0 && expected_tris.size() == 0) begin
			$display("thick_line_round_cap_tessellator_tb: PASS");
		end else begin
			$display("thick_line_round_cap_tessellator_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== thick_line_round_cap_tessellator.f =====
+incdir+rtl/core
rtl/core/tlrc_pkg.sv
rtl/core/tlrc_sqrt.sv
rtl/core/tlrc_div.sv
rtl/core/tlrc_emit.sv
rtl/core/thick_line_round_cap_tessellator.sv
tb/sv/thick_line_round_cap_tessellator_tb.sv
